[hdl/rangefinder_i2c_sequencer_unit_assert.svh]
// assertion macros for the rangefinder sequencer
`ifndef RANGEFINDER_I2C_SEQUENCER_UNIT_ASSERT_SVH
`define RANGEFINDER_I2C_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RFSEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rfseq same-cycle check failed");

// next-cycle implication, checked outside reset
`define RFSEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfseq next-cycle check failed");

`endif

[hdl/rfseq_pkg.sv]
package rfseq_pkg;

    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDataW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_INIT_PAIR_A     = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_INIT_PAIR_B     = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_INIT_PAIR_C     = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_ACQUIRE_PAIR    = 4'd3;
    localparam logic [CfgIdxW-1:0] REG_READ_ADDRESSES  = 4'd4;
    localparam logic [CfgIdxW-1:0] REG_ERROR_MASK      = 4'd5;
    localparam logic [CfgIdxW-1:0] REG_HEALTH_OK_VALUE = 4'd6;
    localparam logic [CfgIdxW-1:0] REG_BUSY_MASK       = 4'd7;

    localparam logic [7:0] BUSY_MASK_RESET = 8'h01;
    localparam logic [7:0] STATUS_READ_LEN = 8'd1;
    localparam logic [7:0] DIST_READ_LEN   = 8'd2;
    localparam logic [1:0] LAST_SETUP_IDX  = 2'd2;

    typedef enum logic [1:0] {
        BS_BUSY = 2'd0,
        BS_OK   = 2'd1,
        BS_TXN  = 2'd2,
        BS_RXN  = 2'd3
    } t_bus_status;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SETUP = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_command;

    typedef enum logic [3:0] {
        SP_PENDING = 4'b0001,
        SP_WRITE   = 4'b0010,
        SP_POLL    = 4'b0100,
        SP_DONE    = 4'b1000
    } t_setup_phase;

    typedef enum logic [6:0] {
        MP_IDLE      = 7'b0000001,
        MP_ACQ       = 7'b0000010,
        MP_ACQ_POLL  = 7'b0000100,
        MP_STAT      = 7'b0001000,
        MP_STAT_POLL = 7'b0010000,
        MP_DIST      = 7'b0100000,
        MP_DIST_POLL = 7'b1000000
    } t_measure_phase;

    typedef struct packed {
        logic          action;
        logic [1:0]    bus_status;
        logic [7:0]    read_byte_high;
        logic [7:0]    read_byte_low;
    } t_in_word;

    typedef struct packed {
        logic [1:0]    command;
        logic [7:0]    reg_address;
        logic [7:0]    reg_data;
        logic          distance_valid;
        logic [15:0]   distance_cm;
        logic          fault;
    } t_out_word;

    typedef struct packed {
        t_setup_phase   setup;
        logic [1:0]     setup_index;
        t_measure_phase measure;
        logic           fault;
    } t_seq_state;

    typedef struct packed {
        logic [15:0] init_pair_a;
        logic [15:0] init_pair_b;
        logic [15:0] init_pair_c;
        logic [15:0] acquire_pair;
        logic [15:0] read_addresses;
        logic [7:0]  error_mask;
        logic [7:0]  health_ok_value;
        logic [7:0]  busy_mask;
    } t_cfg;

endpackage

[hdl/rfseq_step.sv]
module rfseq_step
    import rfseq_pkg::*;
(
    input  t_seq_state i_state,
    input  t_cfg       i_cfg,
    input  t_in_word   i_in,
    output t_seq_state o_state,
    output t_out_word  o_out
);

    logic [15:0] pair;
    logic [1:0]  index_inc;
    logic        healthy;
    logic        still_busy;

    always_comb begin
        unique case (i_state.setup_index)
            2'd0:    pair = i_cfg.init_pair_a;
            2'd1:    pair = i_cfg.init_pair_b;
            default: pair = i_cfg.init_pair_c;
        endcase
    end

    assign index_inc  = i_state.setup_index + 2'd1;
    assign healthy    = (i_in.read_byte_high & i_cfg.error_mask) == i_cfg.health_ok_value;
    assign still_busy = |(i_in.read_byte_high & i_cfg.busy_mask);

    always_comb begin
        o_state = i_state;
        o_out   = '0;
        o_out.command = CMD_NONE;

        if (i_in.action) begin
            // measure request only starts from idle after set-up
            if (i_state.setup == SP_DONE && i_state.measure == MP_IDLE) begin
                o_state.measure = MP_ACQ;
            end
        end else if (i_state.setup != SP_DONE) begin
            unique case (i_state.setup)
                SP_PENDING: begin
                    o_out.command = CMD_SETUP;
                    o_state.setup = SP_WRITE;
                end
                SP_WRITE: begin
                    o_out.command     = CMD_WRITE;
                    o_out.reg_address = pair[15:8];
                    o_out.reg_data    = pair[7:0];
                    o_state.setup     = SP_POLL;
                end
                default: begin
                    unique case (t_bus_status'(i_in.bus_status))
                        BS_OK: begin
                            o_state.setup_index = index_inc;
                            o_state.setup = (i_state.setup_index >= LAST_SETUP_IDX) ?
                                            SP_DONE : SP_WRITE;
                        end
                        BS_TXN:  o_state.setup = SP_WRITE;
                        BS_RXN: begin
                            o_state.fault = 1'b1;
                            o_state.setup = SP_WRITE;
                        end
                        default: ;
                    endcase
                end
            endcase
        end else begin
            unique case (i_state.measure)
                MP_IDLE: ;
                MP_ACQ: begin
                    o_out.command     = CMD_WRITE;
                    o_out.reg_address = i_cfg.acquire_pair[15:8];
                    o_out.reg_data    = i_cfg.acquire_pair[7:0];
                    o_state.measure   = MP_ACQ_POLL;
                end
                MP_ACQ_POLL: begin
                    unique case (t_bus_status'(i_in.bus_status))
                        BS_OK:   o_state.measure = MP_STAT;
                        BS_TXN:  o_state.measure = MP_IDLE;
                        BS_RXN: begin
                            o_state.fault   = 1'b1;
                            o_state.measure = MP_IDLE;
                        end
                        default: ;
                    endcase
                end
                MP_STAT: begin
                    o_out.command     = CMD_READ;
                    o_out.reg_address = i_cfg.read_addresses[15:8];
                    o_out.reg_data    = STATUS_READ_LEN;
                    o_state.measure   = MP_STAT_POLL;
                end
                MP_STAT_POLL: begin
                    if (i_in.bus_status == BS_OK) begin
                        if (healthy) begin
                            o_state.measure = still_busy ? MP_STAT : MP_DIST;
                        end else begin
                            o_state.measure = MP_IDLE;
                        end
                    end else if (i_in.bus_status != BS_BUSY) begin
                        o_state.measure = MP_IDLE;
                    end
                end
                MP_DIST: begin
                    o_out.command     = CMD_READ;
                    o_out.reg_address = i_cfg.read_addresses[7:0];
                    o_out.reg_data    = DIST_READ_LEN;
                    o_state.measure   = MP_DIST_POLL;
                end
                MP_DIST_POLL: begin
                    if (i_in.bus_status == BS_OK) begin
                        o_out.distance_valid = 1'b1;
                        o_out.distance_cm    = {i_in.read_byte_high, i_in.read_byte_low};
                        o_state.measure      = MP_IDLE;
                    end else if (i_in.bus_status != BS_BUSY) begin
                        o_state.measure = MP_IDLE;
                    end
                end
                default: o_state.measure = MP_IDLE;
            endcase
        end

        o_out.fault = o_state.fault;
    end

endmodule

[hdl/rangefinder_i2c_sequencer_unit.sv]
// Rangefinder bus sequencer. Each input word is one scheduler event (fast tick or
// measure request) together with the status and bytes of the last bus transaction;
// each accepted word yields exactly one output word carrying the next bus request,
// an optional big-endian distance in centimetres and the sticky fault flag. After
// reset the ticks ask for bus setup, then write the three set-up pairs with retry on
// a transmit nack; a receive nack during set-up latches the fault. Once set-up is
// done, a measure request taken while idle runs the acquire write, status polling,
// distance read and distance output, one step per tick. The block takes one word
// every clock cycle unless stalled: the step logic sits between the input port and a
// single output register, so a result follows in the next cycle and input ready is
// high whenever that register is empty or being read in the same cycle. Configuration
// registers are written through a plain write port and should only change while the
// block has no word in flight; indexes beyond the register list are ignored.
`include "rangefinder_i2c_sequencer_unit_assert.svh"

module rangefinder_i2c_sequencer_unit
    import rfseq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // event words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_word            i_in_word,
    // result words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_word           o_out_word,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_out_word  r_out;
    t_out_word  n_out;
    logic       r_out_valid;
    logic       in_fire;

    // output register empties the same cycle it is read
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{busy_mask: BUSY_MASK_RESET, default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INIT_PAIR_A:     r_cfg.init_pair_a     <= i_cfg_data;
                REG_INIT_PAIR_B:     r_cfg.init_pair_b     <= i_cfg_data;
                REG_INIT_PAIR_C:     r_cfg.init_pair_c     <= i_cfg_data;
                REG_ACQUIRE_PAIR:    r_cfg.acquire_pair    <= i_cfg_data;
                REG_READ_ADDRESSES:  r_cfg.read_addresses  <= i_cfg_data;
                REG_ERROR_MASK:      r_cfg.error_mask      <= i_cfg_data[7:0];
                REG_HEALTH_OK_VALUE: r_cfg.health_ok_value <= i_cfg_data[7:0];
                REG_BUSY_MASK:       r_cfg.busy_mask       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // one event step: next sequencer state and the result word
    rfseq_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_in    (i_in_word),
        .o_state (n_state),
        .o_out   (n_out)
    );

    // sequencer state advances only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.setup       <= SP_PENDING;
            r_state.setup_index <= 2'd0;
            r_state.measure     <= MP_IDLE;
            r_state.fault       <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // result register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    // a measurement only runs once set-up is finished
    `RFSEQ_ASSERT_NOW(a_measure_after_setup, r_state.measure != MP_IDLE, r_state.setup == SP_DONE)
    // fault flag is sticky until reset
    `RFSEQ_ASSERT_NEXT(a_fault_sticky, r_state.fault, r_state.fault)
    // a distance word never carries a bus request
    `RFSEQ_ASSERT_NOW(a_dist_no_cmd, r_out_valid && r_out.distance_valid, r_out.command == CMD_NONE)
    // the fault shown in a result matches the latched flag it was taken from
    `RFSEQ_ASSERT_NEXT(a_fault_tracks, in_fire, r_out.fault == r_state.fault)

endmodule
